@@ hw/rtl/iiee_pkg.sv @@
// Package for the infix integer expression evaluator.
// Holds the token codes, the status codes, the queued command type and the sizes.
// It depends on nothing else.
package iiee_pkg;

  localparam int WORD_W          = 32;
  localparam int OP_W            = 2;
  localparam int S_TDATA_W       = 40;  // token_value, op_code, zero fill to whole bytes
  localparam int M_TDATA_W       = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic            KIND_INT = 1'b0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB   = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL   = 2'd2;
  localparam logic [OP_W-1:0] OP_DIV   = 2'd3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_TOKEN = 2'd1,
    ST_BAD_END   = 2'd2,
    ST_DIV_ZERO  = 2'd3
  } status_t;

  // token as the back end sees it
  typedef struct packed {
    logic              is_operand;
    logic              is_sum_op;   // + or -
    logic              sub;
    logic              is_div;
    logic              last;
    logic [WORD_W-1:0] value;
  } cmd_t;

endpackage

@@ hw/rtl/iiee_front.sv @@
// Front end: accepts tokens from the input stream and classifies them.
// Holds one classified token until the command queue takes it. Uses iiee_pkg.
module iiee_front import iiee_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] token_value, [33:32] op_code
  input  logic                 s_tlast,   // last_token
  input  logic                 s_tuser,   // token_kind
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output cmd_t                 cmd
);

  logic [OP_W-1:0] op;
  cmd_t            cls;

  assign op       = s_tdata[WORD_W+OP_W-1:WORD_W];
  assign s_tready = !cmd_valid || cmd_ready;

  always_comb begin
    cls.is_operand = (s_tuser == KIND_INT);
    cls.is_sum_op  = (op == OP_ADD) || (op == OP_SUB);
    cls.sub        = (op == OP_SUB);
    cls.is_div     = (op == OP_DIV);
    cls.last       = s_tlast;
    cls.value      = s_tdata[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_tready) begin
      cmd_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      cmd <= cls;
    end
  end

endmodule

@@ hw/rtl/iiee_queue.sv @@
// Command queue between front and back end.
// Small register FIFO of classified tokens. Uses iiee_pkg.
module iiee_queue import iiee_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/iiee_div.sv @@
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
// Restoring division on magnitudes; done pulses once the last quotient bit is in. Uses iiee_pkg.
module iiee_div import iiee_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] dmag;
  logic              neg;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;

  assign shifted  = {rem, quo[WORD_W-1]};
  assign diff     = shifted - {1'b0, dmag};
  assign quotient = neg ? WORD_W'(-quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      cnt  <= CNT_W'(WORD_W - 1);
      rem  <= '0;
      quo  <= dividend[WORD_W-1] ? WORD_W'(-dividend) : dividend;
      dmag <= divisor[WORD_W-1] ? WORD_W'(-divisor) : divisor;
      neg  <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (!diff[WORD_W]) begin
        rem <= diff[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ hw/rtl/iiee_back.sv @@
// Back end: evaluates queued tokens with two precedence levels.
// Keeps sum and term accumulators, uses iiee_div for division, owns the result
// register. Uses iiee_pkg.
module iiee_back import iiee_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_pop,
  input  cmd_t                 cmd,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic [1:0]           m_tuser
);

  typedef enum logic [1:0] {
    TOP_NONE = 2'd0,
    TOP_MUL  = 2'd1,
    TOP_DIV  = 2'd2
  } term_op_t;

  typedef enum logic [1:0] {
    B_RUN = 2'b01,
    B_DIV = 2'b10
  } bstate_t;

  bstate_t           state, state_next;
  logic              expect_operand, expect_operand_next;
  logic [WORD_W-1:0] sum_acc, sum_acc_next;
  logic              pending_sub, pending_sub_next;
  logic [WORD_W-1:0] term_acc, term_acc_next;
  term_op_t          pending_term_op, pending_term_op_next;
  status_t           error_code, error_code_next;
  logic              last_hold;
  logic              div_start;
  logic              div_done;
  logic [WORD_W-1:0] div_q;
  logic              fin;
  status_t           fin_status;
  logic [WORD_W-1:0] fin_value;

  iiee_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (term_acc),
    .divisor  (cmd.value),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_next           = state;
    expect_operand_next  = expect_operand;
    sum_acc_next         = sum_acc;
    pending_sub_next     = pending_sub;
    term_acc_next        = term_acc;
    pending_term_op_next = pending_term_op;
    error_code_next      = error_code;
    cmd_pop              = 1'b0;
    div_start            = 1'b0;
    fin                  = 1'b0;
    fin_status           = ST_OK;
    fin_value            = '0;

    case (state)
      B_RUN: begin
        // a last token waits until the result register is free
        if (cmd_valid && (!cmd.last || !m_tvalid || m_tready)) begin
          cmd_pop = 1'b1;
          if (error_code == ST_OK) begin
            if (expect_operand) begin
              if (!cmd.is_operand) begin
                error_code_next = ST_BAD_TOKEN;
              end else if (pending_term_op == TOP_MUL) begin
                term_acc_next       = term_acc * cmd.value;
                expect_operand_next = 1'b0;
              end else if (pending_term_op == TOP_DIV) begin
                if (cmd.value == '0) begin
                  error_code_next = ST_DIV_ZERO;
                end else begin
                  div_start  = 1'b1;
                  state_next = B_DIV;
                end
              end else begin
                term_acc_next       = cmd.value;
                expect_operand_next = 1'b0;
              end
            end else begin
              if (cmd.is_operand) begin
                error_code_next = ST_BAD_TOKEN;
              end else if (cmd.is_sum_op) begin
                sum_acc_next         = pending_sub ? sum_acc - term_acc : sum_acc + term_acc;
                pending_sub_next     = cmd.sub;
                term_acc_next        = '0;
                pending_term_op_next = TOP_NONE;
                expect_operand_next  = 1'b1;
              end else begin
                pending_term_op_next = cmd.is_div ? TOP_DIV : TOP_MUL;
                expect_operand_next  = 1'b1;
              end
            end
          end
          fin = cmd.last && !div_start;
        end
      end
      B_DIV: begin
        if (div_done) begin
          term_acc_next       = div_q;
          expect_operand_next = 1'b0;
          state_next          = B_RUN;
          fin                 = last_hold;
        end
      end
      default: begin
        state_next = B_RUN;
      end
    endcase

    if (fin) begin
      if (error_code_next == ST_OK && expect_operand_next) begin
        fin_status = ST_BAD_END;
      end else begin
        fin_status = error_code_next;
      end
      if (fin_status == ST_OK) begin
        fin_value = pending_sub_next ? sum_acc_next - term_acc_next
                                     : sum_acc_next + term_acc_next;
      end
      // back to the start of a fresh expression
      expect_operand_next  = 1'b1;
      sum_acc_next         = '0;
      pending_sub_next     = 1'b0;
      term_acc_next        = '0;
      pending_term_op_next = TOP_NONE;
      error_code_next      = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= B_RUN;
      expect_operand  <= 1'b1;
      sum_acc         <= '0;
      pending_sub     <= 1'b0;
      term_acc        <= '0;
      pending_term_op <= TOP_NONE;
      error_code      <= ST_OK;
      m_tvalid        <= 1'b0;
    end else begin
      state           <= state_next;
      expect_operand  <= expect_operand_next;
      sum_acc         <= sum_acc_next;
      pending_sub     <= pending_sub_next;
      term_acc        <= term_acc_next;
      pending_term_op <= pending_term_op_next;
      error_code      <= error_code_next;
      if (fin) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (div_start) begin
      last_hold <= cmd.last;
    end
    if (fin) begin
      m_tdata <= fin_value;
      m_tuser <= fin_status;
    end
  end

endmodule

@@ hw/rtl/infix_int_expression_evaluator.sv @@
// Top level of the infix integer expression evaluator.
// Connects iiee_front, iiee_queue and iiee_back. Uses iiee_pkg.
//
// Input stream: one token per transaction. s_tuser is the token kind (0 integer,
// 1 operator), s_tdata carries the literal and the operator code, s_tlast marks
// the last token of an expression. Output stream: one transaction per expression,
// m_tdata the value (zero on error), m_tuser the status (ok, unexpected token,
// unexpected end, divide by zero).
// The front end registers and classifies each token; a queue of QUEUE_DEPTH
// tokens decouples it from the back end, so the input keeps flowing while the
// back end divides or the output stalls.
// Throughput: one token per cycle for literals after + - * and for operators while
// the queue holds tokens and no last token waits for the output; a literal after /
// waits for the bit-serial divider (one quotient bit per cycle). A last token goes
// through the front-end register, the queue and the result register, a last divisor
// also through the divider. Reset clears the queue, the accumulators and the result
// valid; the block takes tokens in the next cycle. While m_tready is low the
// result holds; the back end keeps evaluating until it meets the next last token,
// then the queue and front end fill and s_tready drops.
module infix_int_expression_evaluator import iiee_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] token_value, [33:32] op_code, rest zero
  input  logic                 s_tlast,   // last_token
  input  logic                 s_tuser,   // token_kind
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] result_value
  output logic [1:0]           m_tuser    // [1:0] status
);

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  iiee_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  iiee_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  iiee_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .cmd       (q_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

@@ hw/rtl/iiee_checker.sv @@
// Port-level checks for the infix integer expression evaluator.
// Tracks expressions in flight from the stream ports; bound to the top level.
// Uses iiee_pkg.
module iiee_checker import iiee_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 s_tlast,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [1:0]           m_tuser
);

  logic [3:0] open_exprs;
  logic       in_last;
  logic       out_xfer;

  assign in_last  = s_tvalid && s_tready && s_tlast;
  assign out_xfer = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_exprs <= '0;
    end else if (in_last && !out_xfer) begin
      open_exprs <= open_exprs + 1'b1;
    end else if (!in_last && out_xfer) begin
      open_exprs <= open_exprs - 1'b1;
    end
  end

  // every result belongs to an expression whose last token went in earlier
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> open_exprs != '0)
    else $error("result without a completed expression");

  a_error_zero_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
    else $error("error result carries a nonzero value");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind infix_int_expression_evaluator iiee_checker u_iiee_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ dv/tb_infix_int_expression_evaluator.sv @@
// Self-checking testbench for infix_int_expression_evaluator: token streams in, values out.
// A scoreboard class predicts each expression's value and status; depends on iiee_pkg and the RTL.
`timescale 1ns / 100ps

module tb_infix_int_expression_evaluator;
  import iiee_pkg::*;

  localparam logic KIND_OP     = 1'b1;
  localparam int   N_RANDOM    = 1450;
  localparam int   PAD_W       = S_TDATA_W - WORD_W - OP_W;
  localparam int   DRAIN_WAIT  = 40;    // longest last-token latency plus margin
  localparam int   LONG_HOLD   = 400;

  typedef enum logic [1:0] {TERM_NONE, TERM_MUL, TERM_DIV} term_op_t;

  typedef struct {
    logic              kind;
    logic [WORD_W-1:0] value;
    logic [OP_W-1:0]   op;
  } token_t;

  typedef struct {
    logic [WORD_W-1:0] value;
    status_t           status;
  } expr_result_t;

  class expr_scoreboard;
    bit                want_operand;
    logic [WORD_W-1:0] sum_acc;
    bit                sum_sub;
    logic [WORD_W-1:0] term_acc;
    term_op_t          term_op;
    status_t           err;
    expr_result_t      expected[$];
    int                n_errors;
    int                n_checked;
    int                n_tokens;
    int                status_count[4];

    function new();
      clear();
      n_errors  = 0;
      n_checked = 0;
      n_tokens  = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function void clear();
      want_operand = 1'b1;
      sum_acc      = '0;
      sum_sub      = 1'b0;
      term_acc     = '0;
      term_op      = TERM_NONE;
      err          = ST_OK;
    endfunction

    function logic [WORD_W-1:0] folded();
      return sum_sub ? sum_acc - term_acc : sum_acc + term_acc;
    endfunction

    // called for every accepted input transaction
    function void note_token(logic kind, logic [WORD_W-1:0] val, logic [OP_W-1:0] op,
                             logic last);
      longint       num;
      longint       den;
      longint       quo;
      expr_result_t r;
      n_tokens++;
      if (err == ST_OK) begin
        if (want_operand) begin
          if (kind != KIND_INT) begin
            err = ST_BAD_TOKEN;
          end else if (term_op == TERM_MUL) begin
            term_acc     = term_acc * val;
            want_operand = 1'b0;
          end else if (term_op == TERM_DIV) begin
            if (val == '0) begin
              err = ST_DIV_ZERO;
            end else begin
              // 64-bit divide so min / -1 wraps instead of overflowing
              num          = $signed(term_acc);
              den          = $signed(val);
              quo          = num / den;
              term_acc     = quo[WORD_W-1:0];
              want_operand = 1'b0;
            end
          end else begin
            term_acc     = val;
            want_operand = 1'b0;
          end
        end else begin
          if (kind == KIND_INT) begin
            err = ST_BAD_TOKEN;
          end else if (op == OP_ADD || op == OP_SUB) begin
            sum_acc      = folded();
            sum_sub      = (op == OP_SUB);
            term_acc     = '0;
            term_op      = TERM_NONE;
            want_operand = 1'b1;
          end else begin
            term_op      = (op == OP_MUL) ? TERM_MUL : TERM_DIV;
            want_operand = 1'b1;
          end
        end
      end
      if (last) begin
        if (err == ST_OK && want_operand) err = ST_BAD_END;
        r.value  = (err == ST_OK) ? folded() : '0;
        r.status = err;
        expected.push_back(r);
        status_count[err]++;
        clear();
      end
    endfunction

    // called for every accepted output transaction
    function void check_result(logic [WORD_W-1:0] value, logic [1:0] status);
      expr_result_t r;
      if (expected.size() == 0) begin
        $display("%0t: result with nothing expected: value %0d status %0d",
                 $time, $signed(value), status);
        n_errors++;
        return;
      end
      r = expected.pop_front();
      n_checked++;
      if (value !== r.value) begin
        $display("%0t: value mismatch: expected %0d actual %0d",
                 $time, $signed(r.value), $signed(value));
        n_errors++;
      end
      if (status !== r.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, r.status, status);
        n_errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // [31:0] token_value, [33:32] op_code, rest zero
  logic                 s_tlast;   // last_token
  logic                 s_tuser;   // token_kind
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // [31:0] result_value
  logic [1:0]           m_tuser;   // [1:0] status

  expr_scoreboard sb = new();
  int             src_idle_pct;
  int             snk_idle_pct;
  int             hold_request;

  infix_int_expression_evaluator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // offer one token, optionally after a random gap, and wait for the transaction
  task automatic send_token(input logic kind, input logic [WORD_W-1:0] val,
                            input logic [OP_W-1:0] op, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_W{1'b0}}, op, val};
    s_tuser  <= kind;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_token(kind, val, op, last);
  endtask

  task automatic lit(input logic [WORD_W-1:0] v, input logic last = 1'b0);
    send_token(KIND_INT, v, 2'($urandom_range(3)), last);
  endtask

  task automatic opr(input logic [OP_W-1:0] op, input logic last = 1'b0);
    send_token(KIND_OP, $urandom, op, last);
  endtask

  function automatic token_t lit_tok(logic [WORD_W-1:0] v);
    token_t t;
    t.kind  = KIND_INT;
    t.value = v;
    t.op    = 2'($urandom_range(3));
    return t;
  endfunction

  function automatic token_t op_tok(logic [OP_W-1:0] op);
    token_t t;
    t.kind  = KIND_OP;
    t.value = $urandom;
    t.op    = op;
    return t;
  endfunction

  // small magnitudes keep products and quotients interesting; extremes hit wrap cases
  function automatic logic [WORD_W-1:0] operand_value();
    logic [WORD_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        v = $urandom_range(1, 20);
        if ($urandom_range(1)) v = -v;
      end
      5: begin
        case ($urandom_range(4))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'hffff_ffff;
          3: v = '0;
          default: v = 32'd1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_random_expr();
    token_t toks[$];
    int     mode;
    int     n_terms;
    int     n_fact;
    bit     div;
    mode    = $urandom_range(99);
    if (mode < 85) begin
      n_terms = $urandom_range(1, 4);
      for (int t = 0; t < n_terms; t++) begin
        if (t > 0) toks.push_back(op_tok($urandom_range(1) ? OP_SUB : OP_ADD));
        toks.push_back(lit_tok(operand_value()));
        n_fact = $urandom_range(1, 3);
        for (int f = 1; f < n_fact; f++) begin
          div = $urandom_range(1);
          toks.push_back(op_tok(div ? OP_DIV : OP_MUL));
          toks.push_back(lit_tok(operand_value()));
        end
      end
      // well-formed prefix cut off by a dangling operator
      if (mode >= 78) toks.push_back(op_tok(2'($urandom_range(3))));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(1)) toks.push_back(lit_tok(operand_value()));
        else toks.push_back(op_tok(2'($urandom_range(3))));
      end
    end
    foreach (toks[i])
      send_token(toks[i].kind, toks[i].value, toks[i].op, i == toks.size() - 1);
  endtask

  // receiver: checks every output transaction, stalls at random or for a long hold
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    int base;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    s_tlast      <= 1'b0;
    s_tuser      <= 1'b0;
    rst          <= 1'b1;
    hold_request = 0;
    src_idle_pct = 17;
    snk_idle_pct = 85;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed expressions
    lit(32'd7, 1'b1);
    opr(OP_ADD, 1'b1);                                   // operator as the only token
    lit(32'd2); opr(OP_ADD); lit(32'd3); opr(OP_MUL); lit(32'd4, 1'b1);
    lit(32'h7fff_ffff); opr(OP_ADD); lit(32'd1, 1'b1);   // add wraps
    lit(32'h8000_0000); opr(OP_DIV); lit(-32'sd1, 1'b1); // min / -1 wraps
    lit(-32'sd7); opr(OP_DIV); lit(32'd2); opr(OP_SUB); lit(32'd5);
    opr(OP_DIV); lit(32'd0); opr(OP_MUL); lit(32'd3, 1'b1); // divide by zero, rest ignored
    lit(32'd3); lit(32'd3, 1'b1);                        // two operands in a row
    lit(32'd5); opr(OP_SUB, 1'b1);                       // ends on an operator

    base = sb.n_tokens;
    while (sb.n_tokens - base < N_RANDOM / 3) send_random_expr();
    src_idle_pct = 85;
    snk_idle_pct = 17;
    while (sb.n_tokens - base < 2 * N_RANDOM / 3) send_random_expr();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_request = LONG_HOLD;   // back up the output so the input stalls
    while (sb.n_tokens - base < N_RANDOM) send_random_expr();
    s_tvalid <= 1'b0;

    while (sb.expected.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d tokens; %0d expressions checked, statuses ok/tok/end/div0: %0d/%0d/%0d/%0d",
             sb.n_tokens, sb.n_checked, sb.status_count[ST_OK], sb.status_count[ST_BAD_TOKEN],
             sb.status_count[ST_BAD_END], sb.status_count[ST_DIV_ZERO]);
    if (sb.n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Timeout with %0d results outstanding", sb.expected.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/iiee_pkg.sv
hw/rtl/iiee_front.sv
hw/rtl/iiee_queue.sv
hw/rtl/iiee_div.sv
hw/rtl/iiee_back.sv
hw/rtl/infix_int_expression_evaluator.sv
hw/rtl/iiee_checker.sv
dv/tb_infix_int_expression_evaluator.sv
